/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, sampled on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/pfdp_pkg.sv */
// ----------------------------------------------------------------------------
// pfdp_pkg
// types and constants shared by the packet fifo with deferred pop
// ----------------------------------------------------------------------------
`default_nettype none

package pfdp_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int PACKET_BITS_DEFAULT = 64;

   localparam int PKT_W  = 64;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 3;
   localparam int FILL_W = 4;
   localparam int RL_W   = 5;

   localparam logic [RL_W-1:0] RING_LENGTH_RESET = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_PEEK   = 3'd2,
      CMD_ACCEPT = 3'd3,
      CMD_REFUSE = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 3'd0,
      ST_FULL       = 3'd1,
      ST_EMPTY      = 3'd2,
      ST_LOCKED     = 3'd3,
      ST_NOT_LOCKED = 3'd4
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [PKT_W-1:0] packet_in;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PKT_W-1:0]  packet_out;
      logic [FILL_W-1:0] fill_count;
      logic              is_empty;
      logic              is_full;
      logic              lock_held;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/packet_fifo_with_deferred_pop_top.sv */
// ----------------------------------------------------------------------------
// packet_fifo_with_deferred_pop_top
// ring-buffer packet fifo with push, pop, peek-and-lock, accept, refuse, clear
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one command with its packet word; rsp channel returns
//   exactly one result per request: status, head packet, fill count and flags.
//   both channels use valid/stall; a request is taken when req_valid is high
//   and req_stall is low.
//   a request taken waits in the execute register; its result is registered
//   in the output register on commit. throughput: one request per cycle
//   while rsp_stall holds no result, set by the single read-modify-write pass
//   over the slot ram (read at next head, write at tail, forward on a match).
//   when rsp_stall holds a result, the request behind it waits in the execute
//   register and req_stall rises until the result is taken.
//   reset clears pointers and lock and sets ring_length to 16; slot contents
//   are not cleared and need no clearing pass.
//   ring_length is written over the apb port at byte address 0; the user must
//   write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module packet_fifo_with_deferred_pop_top import pfdp_pkg::*; #(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int PACKET_BITS = PACKET_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   localparam int AW = $clog2(DEPTH);
   localparam logic REG_RING_LENGTH = 1'b0;

   logic                   exec_valid_ff, exec_valid_in;
   logic [CMD_W-1:0]       cmd_ff;
   logic [PACKET_BITS-1:0] pkt_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff;
   logic [RL_W-1:0]        ring_length_ff;

   logic                   accept;
   logic                   commit;
   logic                   cfg_write;
   rsp_type                result;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [PACKET_BITS-1:0] ram_wdata;
   logic [AW-1:0]          ram_raddr;
   logic [PACKET_BITS-1:0] ram_rdata;

   // the execute stage finishes when the output register is free or emptying
   assign commit    = exec_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = exec_valid_ff && !commit;
   assign accept    = req_valid && !req_stall;

   assign exec_valid_in = accept || (exec_valid_ff && !commit);
   assign rsp_valid_in  = commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         exec_valid_ff <= exec_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (accept) begin
         cmd_ff <= req_data.command;
         pkt_ff <= req_data.packet_in[PACKET_BITS-1:0];
      end
      if (commit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // apb register file
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_RING_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_length_ff <= RING_LENGTH_RESET;
      end else if (cfg_write) begin
         ring_length_ff <= pwdata[RL_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_RING_LENGTH) ? 32'(ring_length_ff) : '0;

   pfdp_ctrl #(
      .DEPTH       (DEPTH),
      .PACKET_BITS (PACKET_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .commit      (commit),
      .cmd         (cmd_ff),
      .pkt         (pkt_ff),
      .ring_length (ring_length_ff),
      .ram_rdata   (ram_rdata),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr   (ram_raddr),
      .result      (result)
   );

   pfdp_ram #(
      .WIDTH (PACKET_BITS),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   `ASSERT_NEXT(a_commit_lands, commit, rsp_valid_ff)
   `ASSERT_SAME(a_held_result_blocks, exec_valid_ff && rsp_valid_ff && rsp_stall, req_stall)
   `ASSERT_SAME(a_empty_not_full, rsp_valid_ff, !(rsp_data_ff.is_empty && rsp_data_ff.is_full))
   `ASSERT_SAME(a_empty_fill_zero, rsp_valid_ff && rsp_data_ff.is_empty, rsp_data_ff.fill_count == '0)

endmodule

`default_nettype wire

/* hw/rtl/pfdp_ram.sv */
// ----------------------------------------------------------------------------
// pfdp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pfdp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hw/rtl/pfdp_ctrl.sv */
// ----------------------------------------------------------------------------
// pfdp_ctrl
// pointer and lock state, command decode, ram access and read forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module pfdp_ctrl import pfdp_pkg::*; #(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int PACKET_BITS = PACKET_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     commit,
   input  wire logic [CMD_W-1:0]         cmd,
   input  wire logic [PACKET_BITS-1:0]   pkt,
   input  wire logic [RL_W-1:0]          ring_length,
   input  wire logic [PACKET_BITS-1:0]   ram_rdata,
   output logic                          ram_we,
   output logic      [$clog2(DEPTH)-1:0] ram_waddr,
   output logic      [PACKET_BITS-1:0]   ram_wdata,
   output logic      [$clog2(DEPTH)-1:0] ram_raddr,
   output rsp_type                       result
);

   localparam int AW    = $clog2(DEPTH);
   localparam int LEN_W = $clog2(DEPTH + 1);
   localparam int CW    = ((LEN_W > RL_W) ? LEN_W : RL_W) + 1;

   logic [AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic                   locked_ff, locked_in;
   logic                   fwd_ff, fwd_in;
   logic [PACKET_BITS-1:0] fwd_data_ff;

   logic [CW-1:0]          len;
   logic [CW-1:0]          rl_ext;
   logic [PACKET_BITS-1:0] head;
   logic                   pre_empty, pre_full;
   logic                   post_empty, post_full;
   logic [CW-1:0]          raw;
   logic [CW-1:0]          wr_ext, rd_ext;
   logic [STAT_W-1:0]      status;
   logic                   give_data;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] p, input logic [CW-1:0] n);
      logic [CW-1:0] nxt;
      nxt = CW'(p) + CW'(1);
      advance = (nxt >= n) ? '0 : nxt[AW-1:0];
   endfunction

   // ring length clamped to two .. DEPTH
   always_comb begin
      rl_ext = CW'(ring_length);
      if (rl_ext < CW'(2)) begin
         len = CW'(2);
      end else if (rl_ext > CW'(DEPTH)) begin
         len = CW'(DEPTH);
      end else begin
         len = rl_ext;
      end
   end

   // a push just written to the slot being read is forwarded
   assign head = fwd_ff ? fwd_data_ff : ram_rdata;

   assign pre_empty = (wr_ptr_ff == rd_ptr_ff);
   assign pre_full  = (advance(wr_ptr_ff, len) == rd_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      locked_in = locked_ff;
      status    = ST_OK;
      give_data = 1'b0;
      ram_we    = 1'b0;
      case (cmd)
         CMD_PUSH: begin
            if (locked_ff) begin
               status = ST_LOCKED;
            end else if (pre_full) begin
               status = ST_FULL;
            end else begin
               ram_we    = commit;
               wr_ptr_in = advance(wr_ptr_ff, len);
            end
         end
         CMD_POP: begin
            if (locked_ff) begin
               status = ST_LOCKED;
            end else if (pre_empty) begin
               status = ST_EMPTY;
            end else begin
               give_data = 1'b1;
               rd_ptr_in = advance(rd_ptr_ff, len);
            end
         end
         CMD_PEEK: begin
            if (locked_ff) begin
               status = ST_LOCKED;
            end else if (pre_empty) begin
               status = ST_EMPTY;
            end else begin
               give_data = 1'b1;
               locked_in = 1'b1;
            end
         end
         CMD_ACCEPT: begin
            if (!locked_ff) begin
               status = ST_NOT_LOCKED;
            end else begin
               if (!pre_empty) begin
                  rd_ptr_in = advance(rd_ptr_ff, len);
               end
               locked_in = 1'b0;
            end
         end
         CMD_REFUSE: begin
            if (!locked_ff) begin
               status = ST_NOT_LOCKED;
            end else begin
               locked_in = 1'b0;
            end
         end
         CMD_CLEAR: begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
         end
         default: begin
         end
      endcase
      if (!commit) begin
         wr_ptr_in = wr_ptr_ff;
         rd_ptr_in = rd_ptr_ff;
         locked_in = locked_ff;
      end
   end

   // flags and fill count after the command
   assign post_empty = (wr_ptr_in == rd_ptr_in);
   assign post_full  = (advance(wr_ptr_in, len) == rd_ptr_in);
   assign wr_ext     = CW'(wr_ptr_in);
   assign rd_ext     = CW'(rd_ptr_in);

   always_comb begin
      if (post_full) begin
         raw = len - CW'(1);
      end else if (wr_ext >= rd_ext) begin
         raw = wr_ext - rd_ext;
      end else if (len + wr_ext >= rd_ext) begin
         raw = len + wr_ext - rd_ext;
      end else begin
         raw = len - CW'(1);
      end
      if (raw > len - CW'(1)) begin
         raw = len - CW'(1);
      end
      if (raw > CW'(15)) begin
         raw = CW'(15);
      end
   end

   always_comb begin
      result.status     = status;
      result.packet_out = give_data ? PKT_W'(head) : '0;
      result.fill_count = raw[FILL_W-1:0];
      result.is_empty   = post_empty;
      result.is_full    = post_full;
      result.lock_held  = locked_in;
   end

   assign ram_waddr = wr_ptr_ff;
   assign ram_wdata = pkt;
   assign ram_raddr = rd_ptr_in;
   assign fwd_in    = ram_we && (wr_ptr_ff == rd_ptr_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         locked_ff <= 1'b0;
         fwd_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         locked_ff <= locked_in;
         fwd_ff    <= fwd_in;
      end
      fwd_data_ff <= pkt;
   end

endmodule

`default_nettype wire

/* verif/packet_fifo_with_deferred_pop_top_tb.sv */
// ----------------------------------------------------------------------------
// packet_fifo_with_deferred_pop_top_tb
// self-checking bench for the ring-buffer packet fifo with deferred pop:
// a scoreboard class mirrors slots, pointers, lock and ring length, predicts
// one result per request and checks every result in order; stimulus is a
// directed opening then phases of random commands at several ring lengths,
// with random idle bursts on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module packet_fifo_with_deferred_pop_top_tb import pfdp_pkg::*; ();

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 220;
   localparam int NUM_PHASES  = 8;
   localparam int REPORT_MAX  = 10;

   // command codes with no operation behind them
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   localparam logic [2:0] ADDR_RING_LENGTH = 3'd0;

   class deferred_pop_scoreboard;
      logic [PKT_W-1:0] slots [DEPTH_DEFAULT];
      bit               written [DEPTH_DEFAULT];
      int               write_ptr;
      int               read_ptr;
      bit               locked;
      logic [RL_W-1:0]  ring_length;
      rsp_type          expected_results [$];
      int               mismatches;

      function new();
         foreach (written[i]) written[i] = 1'b0;
         write_ptr   = 0;
         read_ptr    = 0;
         locked      = 1'b0;
         ring_length = RING_LENGTH_RESET;
         mismatches  = 0;
      endfunction

      function int active_length();
         int len;
         len = ring_length;
         if (len < 2) len = 2;
         if (len > DEPTH_DEFAULT) len = DEPTH_DEFAULT;
         return len;
      endfunction

      function int next_slot(int p);
         int n;
         n = p + 1;
         if (n >= active_length() || n >= DEPTH_DEFAULT) n = 0;
         return n;
      endfunction

      function bit ring_empty();
         return write_ptr == read_ptr;
      endfunction

      function bit ring_full();
         return next_slot(write_ptr) == read_ptr;
      endfunction

      function int held_count();
         int len;
         int raw;
         len = active_length();
         if (ring_full()) raw = len - 1;
         else if (write_ptr >= read_ptr) raw = write_ptr - read_ptr;
         else if (len + write_ptr >= read_ptr) raw = len + write_ptr - read_ptr;
         else raw = len - 1;
         if (raw > len - 1) raw = len - 1;
         if (raw > 15) raw = 15;
         return raw;
      endfunction

      function void note_request(req_type item);
         rsp_type res;
         res = '0;
         res.status = ST_OK;
         case (item.command)
            CMD_PUSH: begin
               if (locked) res.status = ST_LOCKED;
               else if (ring_full()) res.status = ST_FULL;
               else begin
                  slots[write_ptr]   = item.packet_in;
                  written[write_ptr] = 1'b1;
                  write_ptr          = next_slot(write_ptr);
               end
            end
            CMD_POP: begin
               if (locked) res.status = ST_LOCKED;
               else if (ring_empty()) res.status = ST_EMPTY;
               else begin
                  res.packet_out = slots[read_ptr];
                  read_ptr       = next_slot(read_ptr);
               end
            end
            CMD_PEEK: begin
               if (locked) res.status = ST_LOCKED;
               else if (ring_empty()) res.status = ST_EMPTY;
               else begin
                  res.packet_out = slots[read_ptr];
                  locked         = 1'b1;
               end
            end
            CMD_ACCEPT: begin
               if (!locked) res.status = ST_NOT_LOCKED;
               else begin
                  // a clear after the peek leaves nothing to drop
                  if (!ring_empty()) read_ptr = next_slot(read_ptr);
                  locked = 1'b0;
               end
            end
            CMD_REFUSE: begin
               if (!locked) res.status = ST_NOT_LOCKED;
               else locked = 1'b0;
            end
            CMD_CLEAR: begin
               // lock survives a clear
               write_ptr = 0;
               read_ptr  = 0;
            end
            default: begin
            end
         endcase
         res.fill_count = FILL_W'(held_count());
         res.is_empty   = ring_empty();
         res.is_full    = ring_full();
         res.lock_held  = locked;
         expected_results.push_back(res);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("result with no request pending: status %0d packet %h",
                        got.status, got.packet_out);
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status || got.packet_out !== want.packet_out ||
             got.fill_count !== want.fill_count || got.is_empty !== want.is_empty ||
             got.is_full !== want.is_full || got.lock_held !== want.lock_held) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("mismatch expected: status %0d packet %h fill %0d e%b f%b l%b",
                        want.status, want.packet_out, want.fill_count,
                        want.is_empty, want.is_full, want.lock_held);
               $display("         actual:   status %0d packet %h fill %0d e%b f%b l%b",
                        got.status, got.packet_out, got.fill_count,
                        got.is_empty, got.is_full, got.lock_held);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [2:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic [31:0] prdata;
   logic        pready;

   deferred_pop_scoreboard book = new();
   bit quiet_mode = 1'b0;
   int calm_items = 0;
   int cycle_count = 0;

   packet_fifo_with_deferred_pop_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) book.note_request(req_data);
         if (rsp_valid && !rsp_stall) book.check_result(rsp_data);
      end
   end

   // result side back-pressure in bursts, with calm spells
   initial begin : result_stall_gen
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left  = 0;
      forever begin
         @(negedge clock);
         if (quiet_mode) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < 2) begin
            calm_left = $urandom_range(30, 150);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < 10) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("packet_fifo_with_deferred_pop_top regression: fail");
      $finish;
   end

   function automatic req_type make_request(logic [CMD_W-1:0] cmd, logic [PKT_W-1:0] pkt);
      req_type item;
      item.command   = cmd;
      item.packet_in = pkt;
      return item;
   endfunction

   // mostly well-formed traffic: a held lock is usually resolved next
   function automatic req_type random_request(int push_weight);
      logic [CMD_W-1:0] cmd;
      int pick;
      pick = $urandom_range(0, 99);
      if (book.locked && pick < 75) begin
         cmd = (pick < 45) ? CMD_ACCEPT : CMD_REFUSE;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < push_weight) cmd = CMD_PUSH;
         else if (pick < 88) cmd = ($urandom_range(0, 2) == 0) ? CMD_PEEK : CMD_POP;
         else if (pick < 93) cmd = ($urandom_range(0, 1) == 0) ? CMD_ACCEPT : CMD_REFUSE;
         else if (pick < 96) cmd = CMD_CLEAR;
         else cmd = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_LO : CMD_UNUSED_HI;
      end
      // never read a slot that was never written
      if ((cmd == CMD_POP || cmd == CMD_PEEK) && !book.locked && !book.ring_empty() &&
          !book.written[book.read_ptr])
         cmd = CMD_PUSH;
      return make_request(cmd, {$urandom, $urandom});
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input req_type item);
      int gap;
      if (!quiet_mode) begin
         if (calm_items > 0) begin
            calm_items--;
         end else if ($urandom_range(0, 99) < 3) begin
            calm_items = $urandom_range(20, 80);
         end else if ($urandom_range(0, 99) < 15) begin
            gap = $urandom_range(1, 19);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (book.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_ring_length(input logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= ADDR_RING_LENGTH;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      book.ring_length = value[RL_W-1:0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int ring_settings [NUM_PHASES];
      int push_weight;
      ring_settings = '{16, 2, 31, 7, 0, 15, 1, 16};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening on a three-slot ring (two packets at most)
      write_ring_length(32'd3);
      send_request(make_request(CMD_POP, '0));
      send_request(make_request(CMD_PEEK, '0));
      send_request(make_request(CMD_ACCEPT, '0));
      send_request(make_request(CMD_REFUSE, '1));
      send_request(make_request(CMD_PUSH, '0));
      send_request(make_request(CMD_PUSH, '1));
      send_request(make_request(CMD_PUSH, 64'h0123_4567_89ab_cdef));
      send_request(make_request(CMD_PEEK, '0));
      send_request(make_request(CMD_PUSH, 64'h5555_5555_5555_5555));
      send_request(make_request(CMD_POP, '0));
      send_request(make_request(CMD_PEEK, '0));
      send_request(make_request(CMD_REFUSE, '0));
      send_request(make_request(CMD_PEEK, '0));
      send_request(make_request(CMD_ACCEPT, '0));
      send_request(make_request(CMD_POP, '0));
      send_request(make_request(CMD_PUSH, 64'ha5a5_a5a5_a5a5_a5a5));
      send_request(make_request(CMD_PEEK, '0));
      // clear under a lock, then accept with nothing left to drop
      send_request(make_request(CMD_CLEAR, '0));
      send_request(make_request(CMD_ACCEPT, '0));
      send_request(make_request(CMD_UNUSED_LO, '1));
      send_request(make_request(CMD_UNUSED_HI, 64'h8000_0000_0000_0001));
      send_request(make_request(CMD_CLEAR, '1));
      wait_for_drain();

      // random phases; ring length changes without a clear in between
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_ring_length(ring_settings[phase]);
         quiet_mode  = (phase == NUM_PHASES - 1);
         push_weight = $urandom_range(30, 75);
         repeat (PHASE_ITEMS) send_request(random_request(push_weight));
         wait_for_drain();
      end

      repeat (8) @(posedge clock);
      if (book.mismatches == 0 && book.expected_results.size() == 0) begin
         $display("packet_fifo_with_deferred_pop_top regression: pass");
      end else begin
         $display("packet_fifo_with_deferred_pop_top regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
